// ----- sv/mrrt_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrt_pkg
// Types, constants and step functions of the refraction ray trace pipeline.
// ----------------------------------------------------------------------------
package mrrt_pkg;

  localparam int COSINE_FRAC_BITS = 16;

  localparam int COEF_W    = 18;
  localparam int ROT_W     = 3 * COEF_W;
  localparam int CAM_W     = 21;
  localparam int CAM_REG_W = 3 * CAM_W;
  localparam int CFG_W     = CAM_REG_W;
  localparam int FOCAL_W   = 16;
  localparam int THICK_W   = 20;
  localparam int RATIO_W   = 18;
  localparam int IMG_W     = 16;
  localparam int OUT_LEN_W = 24;
  localparam int OUT_COS_W = 18;

  localparam int DIR_W = 26;
  localparam int PT_W  = 48;
  localparam int TMP_W = 48;

  localparam int NUM_W     = 45;
  localparam int DEN_IN_W  = 23;
  localparam int DEN_W     = DEN_IN_W + 1;
  localparam int REM_W     = NUM_W + 1;
  localparam int QUO_W     = 45;
  localparam int DSH_W     = DEN_W + QUO_W;
  localparam int DIV_STEPS = QUO_W;

  localparam int SQ_W     = 51;
  localparam int SQ_STEPS = 25;

  localparam int LATENCY = (SQ_STEPS + 1) + 3 * (DIV_STEPS + 1) + 9;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << COSINE_FRAC_BITS;
  localparam logic signed [PT_W-1:0] INTER_LIM = PT_W'(1) << 40;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PARALLEL  = 2'd1,
    ST_REFLECT   = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_CAMERA = 3'd3,
    REG_FOCAL  = 3'd4,
    REG_THICK  = 3'd5,
    REG_RATIO1 = 3'd6,
    REG_RATIO2 = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } div_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  typedef struct packed {
    logic                     valid;
    logic signed [IMG_W-1:0]  x;
    logic signed [IMG_W-1:0]  y;
    status_t                  status;
    logic                     sat;
    logic                     zero_den;
    sqrt_t                    sq;
    div_t                     dv_a;
    div_t                     dv_b;
    div_t                     dv_c;
    logic [DEN_W-1:0]         den;
    logic signed [DIR_W-1:0]  d_a;
    logic signed [DIR_W-1:0]  d_b;
    logic signed [DIR_W-1:0]  d_c;
    logic signed [PT_W-1:0]   pt_x;
    logic signed [PT_W-1:0]   pt_y;
    logic signed [TMP_W-1:0]  t0;
    logic signed [TMP_W-1:0]  t1;
    logic signed [TMP_W-1:0]  t2;
    logic signed [TMP_W-1:0]  t3;
    logic signed [TMP_W-1:0]  t4;
  } item_t;

  // product back to cosine format, round half away from zero
  function automatic logic signed [TMP_W-1:0] round_frac(input logic signed [TMP_W-1:0] p);
    logic [TMP_W-1:0] m;
    m = p[TMP_W-1] ? -p : p;
    m = (m + (TMP_W'(1) << (COSINE_FRAC_BITS - 1))) >> COSINE_FRAC_BITS;
    return p[TMP_W-1] ? -signed'(m) : signed'(m);
  endfunction

  function automatic logic [DEN_W-1:0] den_of(input logic signed [DEN_IN_W-1:0] d);
    logic [DEN_IN_W-1:0] m;
    m = d[DEN_IN_W-1] ? -d : d;
    return {m, 1'b0};
  endfunction

  function automatic div_t div_start(input logic signed [NUM_W-1:0] n,
                                     input logic signed [DEN_IN_W-1:0] d);
    logic [NUM_W-1:0]    un;
    logic [DEN_IN_W-1:0] ud;
    div_t                r;
    un    = n[NUM_W-1] ? -n : n;
    ud    = d[DEN_IN_W-1] ? -d : d;
    r.rem = {un, 1'b0} + REM_W'(ud);
    r.quo = '0;
    r.neg = n[NUM_W-1] ^ d[DEN_IN_W-1];
    return r;
  endfunction

  function automatic div_t div_step(input div_t a, input logic [DEN_W-1:0] den,
                                    input int unsigned i);
    logic [DSH_W-1:0] sh;
    div_t             r;
    r  = a;
    sh = DSH_W'(den) << i;
    if (DSH_W'(a.rem) >= sh) begin
      r.rem    = a.rem - REM_W'(sh);
      r.quo[i] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [QUO_W:0] div_value(input div_t a);
    logic signed [QUO_W:0] q;
    q = signed'({1'b0, a.quo});
    return a.neg ? -q : q;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t a, input int unsigned j);
    logic [SQ_W-1:0] bit_w;
    sqrt_t           r;
    r     = a;
    bit_w = SQ_W'(1) << (2 * j);
    if (a.v >= a.r + bit_w) begin
      r.v = a.v - (a.r + bit_w);
      r.r = (a.r >> 1) + bit_w;
    end else begin
      r.r = a.r >> 1;
    end
    return r;
  endfunction

  function automatic logic signed [PT_W-1:0] sat_to(input logic signed [PT_W-1:0] v,
                                                   input int unsigned w);
    logic signed [PT_W-1:0] hi;
    logic signed [PT_W-1:0] lo;
    hi = (PT_W'(1) << (w - 1)) - PT_W'(1);
    lo = -hi - PT_W'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic item_t item_sqrt(input item_t it, input int unsigned j);
    item_t r;
    r    = it;
    r.sq = sqrt_step(it.sq, j);
    return r;
  endfunction

  function automatic item_t item_div(input item_t it, input int unsigned i);
    item_t r;
    r      = it;
    r.dv_a = div_step(it.dv_a, it.den, i);
    r.dv_b = div_step(it.dv_b, it.den, i);
    r.dv_c = div_step(it.dv_c, it.den, i);
    return r;
  endfunction

  // division and root side by side; the root needs fewer steps
  function automatic item_t item_both(input item_t it, input int unsigned k);
    item_t r;
    r = item_div(it, QUO_W - 1 - k);
    if (k < SQ_STEPS) r.sq = sqrt_step(it.sq, SQ_STEPS - 1 - k);
    return r;
  endfunction

endpackage

// ----- sv/multimedia_refraction_ray_trace_unit.sv -----
// ----------------------------------------------------------------------------
// multimedia_refraction_ray_trace_unit
// Traces an image ray through two flat interfaces with refraction at each.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is high only during reset.
// Latency is set by the 45-step bit-serial dividers (three passes) and the
// 25-step root, each step a pipeline stage. Results cannot be stalled.
// Reset clears all stage valid bits and loads the register defaults.
module multimedia_refraction_ray_trace_unit import mrrt_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [2:0]                  cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [IMG_W-1:0]     image_x,
  input  logic signed [IMG_W-1:0]     image_y,
  output logic                        done,
  output logic signed [OUT_LEN_W-1:0] point_x,
  output logic signed [OUT_LEN_W-1:0] point_y,
  output logic signed [OUT_LEN_W-1:0] point_z,
  output logic signed [OUT_COS_W-1:0] dir_a,
  output logic signed [OUT_COS_W-1:0] dir_b,
  output logic signed [OUT_COS_W-1:0] dir_c,
  output logic [1:0]                  status
);

  logic [ROT_W-1:0]     rot [3];
  logic [CAM_REG_W-1:0] cam;
  logic [FOCAL_W-1:0]   focal;
  logic [THICK_W-1:0]   thick;
  logic [RATIO_W-1:0]   ratio1;
  logic [RATIO_W-1:0]   ratio2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= '0;
      rot[1] <= '0;
      rot[2] <= '0;
      cam    <= '0;
      focal  <= '0;
      thick  <= '0;
      ratio1 <= RATIO_ONE;
      ratio2 <= RATIO_ONE;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_ROW0:   rot[0] <= cfg_data[ROT_W-1:0];
        REG_ROW1:   rot[1] <= cfg_data[ROT_W-1:0];
        REG_ROW2:   rot[2] <= cfg_data[ROT_W-1:0];
        REG_CAMERA: cam    <= cfg_data[CAM_REG_W-1:0];
        REG_FOCAL:  focal  <= cfg_data[FOCAL_W-1:0];
        REG_THICK:  thick  <= cfg_data[THICK_W-1:0];
        REG_RATIO1: ratio1 <= cfg_data[RATIO_W-1:0];
        REG_RATIO2: ratio2 <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [COEF_W-1:0] rot_e [3][3];
  logic signed [CAM_W-1:0]  cam_x, cam_y, cam_z;
  logic signed [RATIO_W:0]  r1s, r2s;
  logic [2*RATIO_W-1:0]     r1sq, r2sq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        rot_e[i][k] = signed'(rot[i][COEF_W*k +: COEF_W]);
      end
    end
    cam_x = signed'(cam[CAM_W-1:0]);
    cam_y = signed'(cam[2*CAM_W-1:CAM_W]);
    cam_z = signed'(cam[3*CAM_W-1:2*CAM_W]);
    r1s   = signed'({1'b0, ratio1});
    r2s   = signed'({1'b0, ratio2});
    r1sq  = ratio1 * ratio1;
    r2sq  = ratio2 * ratio2;
  end

  assign busy = rst;

  item_t pa [SQ_STEPS+1];
  item_t pv [DIV_STEPS+1];
  item_t pb [DIV_STEPS+1];
  item_t pc [DIV_STEPS+1];
  item_t p2, m1, m2, p3, p4, p6, p7, p8;
  item_t s0_next, p1_next, p2_next, m2_next, p3_next, p4_next, p5_next;
  item_t p6_next, p7_next, p8_next, p9_next;
  logic signed [2*COEF_W-1:0] mprod [3][3];

  // squared length of the camera ray
  always_comb begin
    logic signed [2*IMG_W-1:0] xx, yy;
    logic [2*FOCAL_W-1:0]      ff;
    xx             = image_x * image_x;
    yy             = image_y * image_y;
    ff             = focal * focal;
    s0_next        = '0;
    s0_next.valid  = start && !busy;
    s0_next.x      = image_x;
    s0_next.y      = image_y;
    s0_next.sq.v   = SQ_W'(unsigned'(xx)) + SQ_W'(unsigned'(yy)) + SQ_W'(ff);
  end

  // unit ray: x, y, -f over the root
  always_comb begin
    logic signed [DEN_IN_W-1:0] s;
    logic signed [NUM_W-1:0]    nf;
    p1_next          = pa[SQ_STEPS];
    s                = signed'({1'b0, pa[SQ_STEPS].sq.r[DEN_IN_W-2:0]});
    nf               = NUM_W'(signed'({1'b0, focal})) <<< COSINE_FRAC_BITS;
    p1_next.zero_den = (s == '0);
    p1_next.den      = den_of(s);
    p1_next.dv_a     = div_start(NUM_W'(pa[SQ_STEPS].x) <<< COSINE_FRAC_BITS, s);
    p1_next.dv_b     = div_start(NUM_W'(pa[SQ_STEPS].y) <<< COSINE_FRAC_BITS, s);
    p1_next.dv_c     = div_start(-nf, s);
  end

  always_comb begin
    p2_next = pv[DIV_STEPS];
    if (pv[DIV_STEPS].zero_den) begin
      p2_next.d_a = '0;
      p2_next.d_b = '0;
      p2_next.d_c = '0;
    end else begin
      p2_next.d_a = DIR_W'(div_value(pv[DIV_STEPS].dv_a));
      p2_next.d_b = DIR_W'(div_value(pv[DIV_STEPS].dv_b));
      p2_next.d_c = DIR_W'(div_value(pv[DIV_STEPS].dv_c));
    end
  end

  // rotation into the space frame
  always_comb begin
    logic signed [TMP_W-1:0] acc [3];
    m2_next = m1;
    for (int i = 0; i < 3; i++) begin
      acc[i] = TMP_W'(mprod[i][0]) + TMP_W'(mprod[i][1]) + TMP_W'(mprod[i][2]);
    end
    m2_next.d_a = DIR_W'(round_frac(acc[0]));
    m2_next.d_b = DIR_W'(round_frac(acc[1]));
    m2_next.d_c = DIR_W'(round_frac(acc[2]));
  end

  // first interface: products
  always_comb begin
    logic signed [CAM_W:0] hgt;
    hgt        = signed'({2'b0, thick}) - (CAM_W+1)'(cam_z);
    p3_next    = m2;
    if (m2.d_c == '0) p3_next.status = ST_PARALLEL;
    p3_next.pt_x = hgt * m2.d_a;
    p3_next.pt_y = hgt * m2.d_b;
    p3_next.t0   = m2.d_c * r1s;
    p3_next.t1   = m2.d_a * r1s;
    p3_next.t2   = m2.d_b * r1s;
  end

  always_comb begin
    p4_next      = p3;
    p4_next.t0   = round_frac(p3.t0);
    p4_next.d_a  = DIR_W'(round_frac(p3.t1));
    p4_next.d_b  = DIR_W'(round_frac(p3.t2));
    p4_next.den  = den_of(DEN_IN_W'(p3.d_c));
    p4_next.dv_a = div_start(NUM_W'(p3.pt_x), DEN_IN_W'(p3.d_c));
    p4_next.dv_b = div_start(NUM_W'(p3.pt_y), DEN_IN_W'(p3.d_c));
  end

  always_comb begin
    logic signed [24:0]       crn;
    logic signed [49:0]       crsq;
    logic signed [SQ_W-1:0]   rad;
    crn     = 25'(p4.t0);
    crsq    = crn * crn;
    rad     = (SQ_W'(1) << (2 * COSINE_FRAC_BITS)) - SQ_W'(r1sq) + SQ_W'(crsq);
    p5_next = p4;
    if (p4.status == ST_OK && rad[SQ_W-1]) p5_next.status = ST_REFLECT;
    p5_next.sq.v = rad;
    p5_next.sq.r = '0;
  end

  // first hit point, clamped; refracted vertical cosine
  always_comb begin
    logic signed [PT_W-1:0] xs, ys;
    item_t it;
    it      = pb[DIV_STEPS];
    p6_next = it;
    xs      = PT_W'(cam_x) + PT_W'(div_value(it.dv_a));
    ys      = PT_W'(cam_y) + PT_W'(div_value(it.dv_b));
    if (xs > INTER_LIM) begin
      xs = INTER_LIM;
      p6_next.sat = 1'b1;
    end else if (xs < -INTER_LIM) begin
      xs = -INTER_LIM;
      p6_next.sat = 1'b1;
    end
    if (ys > INTER_LIM) begin
      ys = INTER_LIM;
      p6_next.sat = 1'b1;
    end else if (ys < -INTER_LIM) begin
      ys = -INTER_LIM;
      p6_next.sat = 1'b1;
    end
    p6_next.pt_x = xs;
    p6_next.pt_y = ys;
    p6_next.d_c  = -DIR_W'(it.sq.r);
    if (it.status == ST_OK && it.sq.r == '0) p6_next.status = ST_PARALLEL;
  end

  always_comb begin
    logic signed [THICK_W:0] nthk;
    nthk       = -signed'({1'b0, thick});
    p7_next    = p6;
    p7_next.t0 = p6.d_c * r2s;
    p7_next.t1 = p6.d_a * r2s;
    p7_next.t2 = p6.d_b * r2s;
    p7_next.t3 = nthk * p6.d_a;
    p7_next.t4 = nthk * p6.d_b;
  end

  always_comb begin
    p8_next      = p7;
    p8_next.t0   = round_frac(p7.t0);
    p8_next.d_a  = DIR_W'(round_frac(p7.t1));
    p8_next.d_b  = DIR_W'(round_frac(p7.t2));
    p8_next.den  = den_of(DEN_IN_W'(p7.d_c));
    p8_next.dv_a = div_start(NUM_W'(p7.t3), DEN_IN_W'(p7.d_c));
    p8_next.dv_b = div_start(NUM_W'(p7.t4), DEN_IN_W'(p7.d_c));
  end

  always_comb begin
    logic signed [24:0]     crn;
    logic signed [49:0]     crsq;
    logic signed [SQ_W-1:0] rad;
    crn     = 25'(p8.t0);
    crsq    = crn * crn;
    rad     = (SQ_W'(1) << (2 * COSINE_FRAC_BITS)) - SQ_W'(r2sq) + SQ_W'(crsq);
    p9_next = p8;
    if (p8.status == ST_OK && rad[SQ_W-1]) p9_next.status = ST_REFLECT;
    p9_next.sq.v = rad;
    p9_next.sq.r = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_STEPS; k++) pa[k].valid <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        pv[k].valid <= 1'b0;
        pb[k].valid <= 1'b0;
        pc[k].valid <= 1'b0;
      end
      p2.valid <= 1'b0;
      m1.valid <= 1'b0;
      m2.valid <= 1'b0;
      p3.valid <= 1'b0;
      p4.valid <= 1'b0;
      p6.valid <= 1'b0;
      p7.valid <= 1'b0;
      p8.valid <= 1'b0;
    end else begin
      pa[0] <= s0_next;
      for (int k = 1; k <= SQ_STEPS; k++) pa[k] <= item_sqrt(pa[k-1], SQ_STEPS - k);
      pv[0] <= p1_next;
      for (int k = 1; k <= DIV_STEPS; k++) pv[k] <= item_div(pv[k-1], QUO_W - k);
      p2 <= p2_next;
      m1 <= p2;
      m2 <= m2_next;
      p3 <= p3_next;
      p4 <= p4_next;
      pb[0] <= p5_next;
      for (int k = 1; k <= DIV_STEPS; k++) pb[k] <= item_both(pb[k-1], k - 1);
      p6 <= p6_next;
      p7 <= p7_next;
      p8 <= p8_next;
      pc[0] <= p9_next;
      for (int k = 1; k <= DIV_STEPS; k++) pc[k] <= item_both(pc[k-1], k - 1);
    end
  end

  always_ff @(posedge clk) begin
    mprod[0][0] <= rot_e[0][0] * COEF_W'(p2.d_a);
    mprod[0][1] <= rot_e[0][1] * COEF_W'(p2.d_b);
    mprod[0][2] <= rot_e[0][2] * COEF_W'(p2.d_c);
    mprod[1][0] <= rot_e[1][0] * COEF_W'(p2.d_a);
    mprod[1][1] <= rot_e[1][1] * COEF_W'(p2.d_b);
    mprod[1][2] <= rot_e[1][2] * COEF_W'(p2.d_c);
    mprod[2][0] <= rot_e[2][0] * COEF_W'(p2.d_a);
    mprod[2][1] <= rot_e[2][1] * COEF_W'(p2.d_b);
    mprod[2][2] <= rot_e[2][2] * COEF_W'(p2.d_c);
  end

  // second hit point, final cosines, clamp and status
  logic signed [PT_W-1:0] fx, fy, fa, fb, fc, cx, cy, ca, cb, cc;
  status_t                fstat;

  always_comb begin
    item_t it;
    it    = pc[DIV_STEPS];
    fx    = it.pt_x + PT_W'(div_value(it.dv_a));
    fy    = it.pt_y + PT_W'(div_value(it.dv_b));
    fa    = PT_W'(it.d_a);
    fb    = PT_W'(it.d_b);
    fc    = -PT_W'(it.sq.r);
    cx    = sat_to(fx, OUT_LEN_W);
    cy    = sat_to(fy, OUT_LEN_W);
    ca    = sat_to(fa, OUT_COS_W);
    cb    = sat_to(fb, OUT_COS_W);
    cc    = sat_to(fc, OUT_COS_W);
    fstat = it.status;
    if (it.status == ST_OK) begin
      if (it.sat || cx != fx || cy != fy || ca != fa || cb != fb || cc != fc) begin
        fstat = ST_SATURATED;
      end
    end else begin
      cx = '0;
      cy = '0;
      ca = '0;
      cb = '0;
      cc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pc[DIV_STEPS].valid;
    end
    point_x <= OUT_LEN_W'(cx);
    point_y <= OUT_LEN_W'(cy);
    dir_a   <= OUT_COS_W'(ca);
    dir_b   <= OUT_COS_W'(cb);
    dir_c   <= OUT_COS_W'(cc);
    status  <= fstat;
  end

  assign point_z = '0;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("request did not complete after the pipeline latency");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_PARALLEL || status == ST_REFLECT) |->
      point_x == '0 && point_y == '0 && dir_a == '0 && dir_b == '0 && dir_c == '0)
    else $error("failed ray with nonzero result fields");

  a_down: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OK || status == ST_SATURATED) |-> dir_c[OUT_COS_W-1] || dir_c == '0)
    else $error("final vertical cosine positive");

endmodule
